/* rtl/mcc_pkg.sv */
// ----------------------------------------------------------------------------
// Morse codec package
// Shared constants, the letter and digit code table, and the job type that
// travels from the front end to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    localparam int MAX_SYMBOLS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CODE_COUNT  = 36;
    localparam int CODE_LEN_W  = 3;
    localparam int CODE_BITS_W = 5;
    localparam int CODE_IDX_W  = 6;

    localparam logic [CODE_IDX_W-1:0] LETTER_COUNT = CODE_IDX_W'(26);

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Symbol k of a code is bit k of bits: 1 is a dash, 0 is a dot.
    typedef struct packed {
        logic [CODE_LEN_W-1:0]  len;
        logic [CODE_BITS_W-1:0] bits;
    } t_code;

    // A job emits sym_count dots and dashes, then the tail character,
    // which closes the run.
    typedef struct packed {
        logic [CODE_LEN_W-1:0]  sym_count;
        logic [CODE_BITS_W-1:0] sym_bits;
        logic [7:0]             tail;
    } t_job;

    function automatic t_code code_of(input logic [CODE_IDX_W-1:0] idx);
        t_code c;
        unique case (idx)
            6'd0:    c = '{len: 3'd2, bits: 5'b00010}; // a
            6'd1:    c = '{len: 3'd4, bits: 5'b00001}; // b
            6'd2:    c = '{len: 3'd4, bits: 5'b00101}; // c
            6'd3:    c = '{len: 3'd3, bits: 5'b00001}; // d
            6'd4:    c = '{len: 3'd1, bits: 5'b00000}; // e
            6'd5:    c = '{len: 3'd4, bits: 5'b00100}; // f
            6'd6:    c = '{len: 3'd3, bits: 5'b00011}; // g
            6'd7:    c = '{len: 3'd4, bits: 5'b00000}; // h
            6'd8:    c = '{len: 3'd2, bits: 5'b00000}; // i
            6'd9:    c = '{len: 3'd4, bits: 5'b01110}; // j
            6'd10:   c = '{len: 3'd3, bits: 5'b00101}; // k
            6'd11:   c = '{len: 3'd4, bits: 5'b00010}; // l
            6'd12:   c = '{len: 3'd2, bits: 5'b00011}; // m
            6'd13:   c = '{len: 3'd2, bits: 5'b00001}; // n
            6'd14:   c = '{len: 3'd3, bits: 5'b00111}; // o
            6'd15:   c = '{len: 3'd4, bits: 5'b00110}; // p
            6'd16:   c = '{len: 3'd4, bits: 5'b01011}; // q
            6'd17:   c = '{len: 3'd3, bits: 5'b00010}; // r
            6'd18:   c = '{len: 3'd3, bits: 5'b00000}; // s
            6'd19:   c = '{len: 3'd1, bits: 5'b00001}; // t
            6'd20:   c = '{len: 3'd3, bits: 5'b00100}; // u
            6'd21:   c = '{len: 3'd4, bits: 5'b01000}; // v
            6'd22:   c = '{len: 3'd3, bits: 5'b00110}; // w
            6'd23:   c = '{len: 3'd4, bits: 5'b01001}; // x
            6'd24:   c = '{len: 3'd4, bits: 5'b01101}; // y
            6'd25:   c = '{len: 3'd4, bits: 5'b00011}; // z
            6'd26:   c = '{len: 3'd5, bits: 5'b11111}; // 0
            6'd27:   c = '{len: 3'd5, bits: 5'b11110}; // 1
            6'd28:   c = '{len: 3'd5, bits: 5'b11100}; // 2
            6'd29:   c = '{len: 3'd5, bits: 5'b11000}; // 3
            6'd30:   c = '{len: 3'd5, bits: 5'b10000}; // 4
            6'd31:   c = '{len: 3'd5, bits: 5'b00000}; // 5
            6'd32:   c = '{len: 3'd5, bits: 5'b00001}; // 6
            6'd33:   c = '{len: 3'd5, bits: 5'b00011}; // 7
            6'd34:   c = '{len: 3'd5, bits: 5'b00111}; // 8
            6'd35:   c = '{len: 3'd5, bits: 5'b01111}; // 9
            default: c = '{len: 3'd0, bits: 5'b00000};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] glyph_of(input logic [CODE_IDX_W-1:0] idx);
        logic [7:0] g;
        if (idx < LETTER_COUNT) begin
            g = CH_LOWER_A + {2'b00, idx};
        end else begin
            g = CH_DIGIT_0 + {2'b00, idx - LETTER_COUNT};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/morse_code_codec_core.sv */
// ----------------------------------------------------------------------------
// Morse codec core
// Encodes ASCII letters and digits to international Morse, or decodes
// dot/dash groups back to lowercase letters and digits.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  --------------------------------------
//  input     push / full          i_char_in[7:0], i_end_of_message
//  result    pop / empty          o_char_out[7:0], o_last_of_run
//  config    i_cfg_we             i_cfg_wdata (decode_mode)
//
//  A byte enters whenever full is low. In decode mode each byte makes at
//  most one result transfer. In encode mode a letter or digit makes two to six
//  result transfers, so even with the result side always popping, the single
//  result port, not the input, limits how fast encoded bytes are taken.
//  Reset (synchronous, active low) clears the mode, the decode group and
//  both queues. Either side may stall independently; the job queue absorbs
//  up to QUEUE_DEPTH pending jobs before full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_codec_core #(
    parameter int MAX_SYMBOLS = mcc_pkg::MAX_SYMBOLS_DEF,
    parameter int QUEUE_DEPTH = mcc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write.
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    // Input byte channel.
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_end_of_message,
    // Result channel.
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_char_out,
    output logic            o_last_of_run
);

    // Front end to queue: one job per byte that produces any output. A job
    // is a run of dots and dashes followed by one closing character.
    logic          job_push;
    mcc_pkg::t_job job_in;
    logic          queue_full;

    // Queue head to the serializer.
    logic          head_valid;
    mcc_pkg::t_job head_job;
    logic          head_pop;

    // The front end owns the mode register and the decode group, and it
    // classifies each byte as soon as it is accepted. Bytes that produce
    // nothing never reach the queue.
    mcc_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_push           (push),
        .i_char_in        (i_char_in),
        .i_end_of_message (i_end_of_message),
        .i_queue_full     (queue_full),
        .o_full           (full),
        .o_job_push       (job_push),
        .o_job            (job_in)
    );

    // The queue decouples the byte side from the character side, so a
    // stalled result port does not stop bytes until the queue fills.
    mcc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_data  (head_job),
        .i_pop   (head_pop)
    );

    // The serializer emits one character per cycle into the result register
    // while it is empty or popped, and retires a job in the same cycle it emits
    // the closing character, so consecutive jobs follow each other without a gap.
    mcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (head_valid),
        .i_job         (head_job),
        .o_job_pop     (head_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_char_out    (o_char_out),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

/* rtl/mcc_front.sv */
// ----------------------------------------------------------------------------
// Morse codec front end
// Accepts input bytes, holds the mode and the decode group, and turns each
// byte into at most one job for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_front #(
    parameter int MAX_SYMBOLS = mcc_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_char_in,
    input  wire logic          i_end_of_message,
    input  wire logic          i_queue_full,
    output logic               o_full,
    output logic               o_job_push,
    output mcc_pkg::t_job      o_job
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam logic [MAX_SYMBOLS-1:0] SYM_ONE = MAX_SYMBOLS'(1);

    logic                   r_decode_mode;
    logic [MAX_SYMBOLS-1:0] r_sym_bits;
    logic [CNT_W-1:0]       r_sym_count;
    logic                   r_group_invalid;

    logic [MAX_SYMBOLS-1:0] n_sym_bits;
    logic [CNT_W-1:0]       n_sym_count;
    logic                   n_group_invalid;

    logic                              accept;
    logic                              is_upper, is_lower, is_digit, enc_valid;
    logic [7:0]                        lower_c;
    logic [mcc_pkg::CODE_IDX_W-1:0]    enc_idx;
    mcc_pkg::t_code                    enc_code;
    logic                              is_sym, is_sp, group_empty, ending;
    logic [MAX_SYMBOLS-1:0]            bits1;
    logic [CNT_W-1:0]                  cnt1;
    logic                              inv1;
    logic                              hit_any, matched, dec_emit;
    logic [7:0]                        glyph;
    mcc_pkg::t_code                    entry;

    assign accept = i_push && !i_queue_full;
    assign o_full = i_queue_full;

    // Encode side: case-folded letter or digit to table index.
    always_comb begin
        is_upper  = (i_char_in >= mcc_pkg::CH_UPPER_A) && (i_char_in <= mcc_pkg::CH_UPPER_Z);
        is_lower  = (i_char_in >= mcc_pkg::CH_LOWER_A) && (i_char_in <= mcc_pkg::CH_LOWER_Z);
        is_digit  = (i_char_in >= mcc_pkg::CH_DIGIT_0) && (i_char_in <= mcc_pkg::CH_DIGIT_9);
        enc_valid = is_upper || is_lower || is_digit;
        lower_c   = i_char_in | mcc_pkg::CASE_BIT;
        if (is_digit) begin
            enc_idx = mcc_pkg::CODE_IDX_W'(i_char_in - mcc_pkg::CH_DIGIT_0)
                      + mcc_pkg::LETTER_COUNT;
        end else begin
            enc_idx = mcc_pkg::CODE_IDX_W'(lower_c - mcc_pkg::CH_LOWER_A);
        end
        enc_code = mcc_pkg::code_of(enc_idx);
    end

    // Decode side: the group after this byte, then whether it ends here.
    always_comb begin
        is_sym = (i_char_in == mcc_pkg::CH_DOT) || (i_char_in == mcc_pkg::CH_DASH);
        is_sp  = (i_char_in == mcc_pkg::CH_SPACE);
        bits1  = r_sym_bits;
        cnt1   = r_sym_count;
        inv1   = r_group_invalid;
        if (is_sym) begin
            if (r_sym_count < CNT_W'(MAX_SYMBOLS)) begin
                if (i_char_in == mcc_pkg::CH_DASH) begin
                    bits1 = r_sym_bits | (SYM_ONE << r_sym_count);
                end
                cnt1 = r_sym_count + CNT_W'(1);
            end else begin
                inv1 = 1'b1;
            end
        end else if (!is_sp) begin
            inv1 = 1'b1;
        end
        group_empty = (r_sym_count == '0) && !r_group_invalid;
        if (is_sp) begin
            ending = !group_empty;
        end else begin
            ending = i_end_of_message && ((cnt1 != '0) || inv1);
        end
    end

    // Codes are unique, so at most one entry hits and the glyphs can be ORed.
    always_comb begin
        entry   = '0;
        hit_any = 1'b0;
        glyph   = '0;
        for (int i = 0; i < mcc_pkg::CODE_COUNT; i++) begin
            entry = mcc_pkg::code_of(mcc_pkg::CODE_IDX_W'(i));
            if ((cnt1 == CNT_W'(entry.len)) &&
                (bits1[mcc_pkg::CODE_BITS_W-1:0] == entry.bits)) begin
                hit_any = 1'b1;
                glyph   = glyph | mcc_pkg::glyph_of(mcc_pkg::CODE_IDX_W'(i));
            end
        end
        matched  = hit_any && !inv1;
        dec_emit = (is_sp && group_empty) || (ending && matched);
    end

    always_comb begin
        if (r_decode_mode) begin
            o_job.sym_count = '0;
            o_job.sym_bits  = '0;
            o_job.tail      = (is_sp && group_empty) ? mcc_pkg::CH_SPACE : glyph;
            o_job_push      = accept && dec_emit;
        end else begin
            o_job.sym_count = enc_code.len;
            o_job.sym_bits  = enc_code.bits;
            o_job.tail      = mcc_pkg::CH_SPACE;
            o_job_push      = accept && enc_valid;
        end
    end

    always_comb begin
        n_sym_bits      = r_sym_bits;
        n_sym_count     = r_sym_count;
        n_group_invalid = r_group_invalid;
        if (accept && r_decode_mode) begin
            if (ending) begin
                n_sym_bits      = '0;
                n_sym_count     = '0;
                n_group_invalid = 1'b0;
            end else begin
                n_sym_bits      = bits1;
                n_sym_count     = cnt1;
                n_group_invalid = inv1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode   <= 1'b0;
            r_sym_bits      <= '0;
            r_sym_count     <= '0;
            r_group_invalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_decode_mode <= i_cfg_wdata;
            end
            r_sym_bits      <= n_sym_bits;
            r_sym_count     <= n_sym_count;
            r_group_invalid <= n_group_invalid;
        end
    end

endmodule

`default_nettype wire

/* rtl/mcc_fifo.sv */
// ----------------------------------------------------------------------------
// Morse codec job queue
// A small first-in first-out queue of jobs between the front end and the
// serializer; the head is visible without a read cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_fifo #(
    parameter int DEPTH = mcc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mcc_pkg::t_job i_data,
    output logic               o_full,
    output logic               o_valid,
    output mcc_pkg::t_job      o_data,
    input  wire logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcc_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/mcc_back.sv */
// ----------------------------------------------------------------------------
// Morse codec serializer
// Walks the job at the head of the queue one character per cycle into the
// result register when free, and retires the job with its closing character.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire mcc_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_char_out,
    output logic               o_last_of_run
);

    logic [mcc_pkg::CODE_LEN_W-1:0] r_pos;
    logic                           r_valid;
    logic [7:0]                     r_char;
    logic                           r_last;

    logic [mcc_pkg::CODE_LEN_W-1:0] n_pos;
    logic                           n_valid;

    logic       out_free, emit, at_tail;
    logic [7:0] sym_char;

    always_comb begin
        out_free  = !r_valid || i_pop;
        emit      = out_free && i_job_valid;
        at_tail   = (r_pos == i_job.sym_count);
        sym_char  = i_job.sym_bits[r_pos] ? mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
        o_job_pop = emit && at_tail;
        n_pos     = r_pos;
        if (emit) begin
            n_pos = at_tail ? '0 : r_pos + mcc_pkg::CODE_LEN_W'(1);
        end
        if (emit) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= at_tail ? i_job.tail : sym_char;
            r_last <= at_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    assign o_empty       = !r_valid;
    assign o_char_out    = r_char;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

/* rtl/mcc_checker.sv */
// ----------------------------------------------------------------------------
// Morse codec port checker
// Watches the ports of the codec core and flags results that break the
// codec's output rules or the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_full,
    input wire logic       i_empty,
    input wire logic       i_pop,
    input wire logic [7:0] i_char_out,
    input wire logic       i_last_of_run
);

    logic is_symbol;
    logic is_legal;

    assign is_symbol = (i_char_out == mcc_pkg::CH_DOT) || (i_char_out == mcc_pkg::CH_DASH);
    assign is_legal  = is_symbol || (i_char_out == mcc_pkg::CH_SPACE)
                    || ((i_char_out >= mcc_pkg::CH_LOWER_A) && (i_char_out <= mcc_pkg::CH_LOWER_Z))
                    || ((i_char_out >= mcc_pkg::CH_DIGIT_0) && (i_char_out <= mcc_pkg::CH_DIGIT_9));

    // A waiting result that is not taken stays put.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_char_out) && $stable(i_last_of_run)))
        else $error("result changed while stalled");

    // Only dots, dashes, spaces, lowercase letters and digits come out.
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> is_legal)
        else $error("illegal result character");

    // Dots and dashes never close a run; every other character does.
    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (is_symbol != i_last_of_run))
        else $error("run boundary on the wrong character");

    // Reset leaves both sides empty and ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_empty && !i_full))
        else $error("queues not cleared by reset");

endmodule

bind morse_code_codec_core mcc_checker u_mcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_full        (full),
    .i_empty       (empty),
    .i_pop         (pop),
    .i_char_out    (o_char_out),
    .i_last_of_run (o_last_of_run)
);

`default_nettype wire

/* sim/tb_morse_code_codec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse codec core testbench
// Feeds ASCII bytes through the codec in both modes. Each byte is predicted
// when it is offered, and every popped result is checked against the oldest
// predicted result. Both sides idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------

module tb_morse_code_codec_core;

    // Group length limit of the decoder, also passed to the block.
    localparam int GROUP_MAX = 5;
    // Letters a-z followed by digits 0-9.
    localparam int CODE_COUNT = 36;
    localparam int LETTERS = 26;

    // Quiet cycles after the last expected result before the next phase, so
    // that a stray late result is caught as unexpected.
    localparam int SETTLE_CYCLES = 40;
    // Hard stop for the whole run; far above the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] ASCII_DOT     = 8'h2E;
    localparam logic [7:0] ASCII_DASH    = 8'h2D;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_TAB     = 8'h09;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_DIGIT_0 = 8'h30;
    localparam logic [7:0] ASCII_DIGIT_9 = 8'h39;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One byte offered on the input side.
    typedef struct {
        logic [7:0] chr;
        logic       eom;
    } t_morse_item;

    // One character expected on the result side.
    typedef struct {
        logic [7:0] chr;
        logic       last;
    } t_morse_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_char_in = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_char_out;
    logic       o_last_of_run;

    morse_code_codec_core #(
        .MAX_SYMBOLS(GROUP_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_char_in       (i_char_in),
        .i_end_of_message(i_end_of_message),
        .empty           (empty),
        .pop             (pop),
        .o_char_out      (o_char_out),
        .o_last_of_run   (o_last_of_run)
    );

    // Bytes waiting to be offered, and characters waiting to be popped.
    t_morse_item byte_pending_q[$];
    t_morse_out  morse_exp_q[$];

    // Mirror of the mode register and of the decoder's symbol group.
    logic       mode_shadow = MODE_ENCODE;
    logic [4:0] grp_bits = '0;
    logic [2:0] grp_count = '0;
    logic       grp_bad = 1'b0;

    // Idling odds in percent, set per phase by the stimulus process.
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;

    bit          failed = 1'b0;
    int          cycle_count = 0;
    t_morse_item drv_next;
    t_morse_out  mon_exp;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Dots and dashes of each letter and digit, in table order.
    function automatic string morse_of(input int idx);
        case (idx)
            0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
            4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
            8: return "..";     9: return ".---";  10: return "-.-";   11: return ".-..";
            12: return "--";   13: return "-.";    14: return "---";   15: return ".--.";
            16: return "--.-"; 17: return ".-.";   18: return "...";   19: return "-";
            20: return "..-";  21: return "...-";  22: return ".--";   23: return "-..-";
            24: return "-.--"; 25: return "--..";  26: return "-----"; 27: return ".----";
            28: return "..---"; 29: return "...--"; 30: return "....-"; 31: return ".....";
            32: return "-....";  33: return "--...";  34: return "---..";
            default: return "----.";
        endcase
    endfunction

    // Ends the current symbol group. Returns the decoded character, or -1
    // when the group is empty, marked bad, or matches no code.
    function automatic int close_group();
        int    found;
        string code;
        bit    same;
        found = -1;
        if (!grp_bad && grp_count != 0) begin
            for (int i = 0; i < CODE_COUNT; i++) begin
                code = morse_of(i);
                same = (found < 0) && (code.len() == int'(grp_count));
                for (int k = 0; k < code.len() && same; k++) begin
                    if ((code[k] == ASCII_DASH) != grp_bits[k]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    found = (i < LETTERS) ? int'(ASCII_LOWER_A) + i
                                          : int'(ASCII_DIGIT_0) + i - LETTERS;
                end
            end
        end
        grp_bits = '0;
        grp_count = '0;
        grp_bad = 1'b0;
        return found;
    endfunction

    // Works out the characters that one byte causes and queues them, the
    // final one flagged as the end of the run.
    function automatic void predict_results(input logic [7:0] chr, input logic eom);
        logic [7:0] outs[$];
        logic [7:0] lc;
        int         idx;
        int         g;
        string      code;
        t_morse_out r;
        if (mode_shadow == MODE_ENCODE) begin
            idx = -1;
            lc = chr;
            if (chr >= ASCII_UPPER_A && chr <= ASCII_UPPER_Z) begin
                lc = chr | ASCII_CASE;
            end
            if (lc >= ASCII_LOWER_A && lc <= ASCII_LOWER_Z) begin
                idx = int'(lc - ASCII_LOWER_A);
            end else if (chr >= ASCII_DIGIT_0 && chr <= ASCII_DIGIT_9) begin
                idx = int'(chr - ASCII_DIGIT_0) + LETTERS;
            end
            // Encoding never touches the decode group, end of message or not.
            if (idx >= 0) begin
                code = morse_of(idx);
                for (int k = 0; k < code.len(); k++) begin
                    outs.push_back(code[k]);
                end
                outs.push_back(ASCII_SPACE);
            end
        end else begin
            if (chr == ASCII_DOT || chr == ASCII_DASH) begin
                // Symbols past the limit are dropped and spoil the group.
                if (grp_count < GROUP_MAX) begin
                    grp_bits[grp_count] = (chr == ASCII_DASH);
                    grp_count = grp_count + 3'd1;
                end else begin
                    grp_bad = 1'b1;
                end
            end else if (chr == ASCII_SPACE) begin
                // A space alone is a word gap; a spoiled group is not empty.
                if (grp_count == 0 && !grp_bad) begin
                    outs.push_back(ASCII_SPACE);
                end else begin
                    g = close_group();
                    if (g >= 0) outs.push_back(g[7:0]);
                end
            end else begin
                grp_bad = 1'b1;
            end
            if (eom && (grp_count != 0 || grp_bad)) begin
                g = close_group();
                if (g >= 0) outs.push_back(g[7:0]);
            end
        end
        foreach (outs[i]) begin
            r.chr = outs[i];
            r.last = (i == outs.size() - 1);
            morse_exp_q.push_back(r);
        end
    endfunction

    // Driver: offers the next pending byte whenever the input slot is free.
    // A byte is predicted as it is offered; it stays on the port until its
    // transfer, so bytes are accepted in the order they are predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (byte_pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drv_next = byte_pending_q.pop_front();
                predict_results(drv_next.chr, drv_next.eom);
                i_char_in <= drv_next.chr;
                i_end_of_message <= drv_next.eom;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (morse_exp_q.size() == 0) begin
                    $error("unexpected result: char_out %h last_of_run %b",
                           o_char_out, o_last_of_run);
                    failed = 1'b1;
                end else begin
                    mon_exp = morse_exp_q.pop_front();
                    if (o_char_out !== mon_exp.chr) begin
                        $error("char_out: expected %h, actual %h", mon_exp.chr, o_char_out);
                        failed = 1'b1;
                    end
                    if (o_last_of_run !== mon_exp.last) begin
                        $error("last_of_run: expected %b, actual %b",
                               mon_exp.last, o_last_of_run);
                        failed = 1'b1;
                    end
                end
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog for a block that hangs or loses results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] chr, input logic eom);
        t_morse_item it;
        it.chr = chr;
        it.eom = eom;
        byte_pending_q.push_back(it);
    endtask

    // Adds the symbols of code idx; the end-of-message flag may ride on the
    // last symbol so that the group is flushed without a space.
    task automatic add_symbols(input int idx, input logic eom_on_last);
        string code;
        code = morse_of(idx);
        for (int k = 0; k < code.len(); k++) begin
            add_byte(code[k], eom_on_last && (k == code.len() - 1));
        end
    endtask

    // Encode traffic: mostly letters of either case and digits, the rest
    // arbitrary bytes, with a random end-of-message flag.
    task automatic add_encode_random(input int count);
        int idx;
        logic [7:0] chr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) begin
                idx = $urandom_range(CODE_COUNT - 1);
                if (idx < LETTERS) begin
                    chr = ASCII_LOWER_A + 8'(idx);
                    if ($urandom_range(1)) chr = chr & ~ASCII_CASE;
                end else begin
                    chr = ASCII_DIGIT_0 + 8'(idx - LETTERS);
                end
            end else begin
                chr = 8'($urandom_range(255));
            end
            add_byte(chr, 1'($urandom_range(1)));
        end
    endtask

    // Decode traffic: mostly well-formed groups with random content, plus
    // word gaps, overlong groups, stray bytes and groups of random symbols.
    task automatic add_decode_random(input int count);
        int start;
        int pick;
        int len;
        start = byte_pending_q.size();
        while (byte_pending_q.size() - start < count) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if ($urandom_range(3) == 0) begin
                    add_symbols($urandom_range(CODE_COUNT - 1), 1'b1);
                end else begin
                    add_symbols($urandom_range(CODE_COUNT - 1), 1'b0);
                    add_byte(ASCII_SPACE, 1'($urandom_range(1)));
                end
            end else if (pick < 75) begin
                add_byte(ASCII_SPACE, 1'b0);
            end else if (pick < 85) begin
                len = $urandom_range(8, GROUP_MAX + 1);
                for (int k = 0; k < len; k++) begin
                    add_byte($urandom_range(1) ? ASCII_DASH : ASCII_DOT, 1'b0);
                end
                add_byte(ASCII_SPACE, 1'b0);
            end else if (pick < 92) begin
                add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                len = $urandom_range(GROUP_MAX, 1);
                for (int k = 0; k < len; k++) begin
                    add_byte($urandom_range(1) ? ASCII_DASH : ASCII_DOT, 1'b0);
                end
                add_byte(ASCII_SPACE, 1'b0);
            end
        end
    endtask

    // Waits until every byte has been transferred and every result popped,
    // then stays quiet for a while so late extra results are caught.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (byte_pending_q.size() != 0 || push || morse_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the mode register; only called while the block is idle.
    task automatic write_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_shadow = mode;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed encode: case folding, table ends, and the bytes right
        // around the letter and digit ranges, which must emit nothing.
        write_mode(MODE_ENCODE);
        add_byte("A", 1'b0);
        add_byte("z", 1'b0);
        add_byte("0", 1'b0);
        add_byte("9", 1'b1);
        add_byte(ASCII_SPACE, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte("@", 1'b0);
        add_byte("{", 1'b0);
        add_byte("/", 1'b0);
        add_byte(":", 1'b1);
        wait_idle();

        // A mode change keeps a half-built group: ".-" survives an encoded
        // letter and is decoded by the space that follows.
        write_mode(MODE_DECODE);
        add_byte(ASCII_DOT, 1'b0);
        add_byte(ASCII_DASH, 1'b0);
        wait_idle();
        write_mode(MODE_ENCODE);
        add_byte("e", 1'b0);
        wait_idle();
        write_mode(MODE_DECODE);
        add_byte(ASCII_SPACE, 1'b0);
        // A space with nothing collected is a word gap.
        add_byte(ASCII_SPACE, 1'b0);
        // Six symbols overflow the group; the flush then emits nothing.
        add_symbols(26, 1'b0);
        add_byte(ASCII_DOT, 1'b1);
        // A tab is not a separator; it spoils the group and the flag clears it.
        add_byte(ASCII_TAB, 1'b1);
        // "..--" is well formed but matches no code.
        add_byte(ASCII_DOT, 1'b0);
        add_byte(ASCII_DOT, 1'b0);
        add_byte(ASCII_DASH, 1'b0);
        add_byte(ASCII_DASH, 1'b1);
        wait_idle();

        // Random part: four idling phases, each in both modes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            write_mode(MODE_ENCODE);
            add_encode_random(62);
            wait_idle();
            write_mode(MODE_DECODE);
            add_decode_random(62);
            wait_idle();
        end

        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
